>>> src/srs_pkg.sv
// srs_pkg: shared types and codes for the sortable record stack.
// No dependencies; imported by srs_mem and sortable_record_stack.
`default_nettype none
package srs_pkg;

   localparam int DEPTH_DEFAULT = 128;

   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;
   localparam logic [1:0] MODE_SORT = 2'd2;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] student_id;
      logic signed [31:0] score;
      logic [15:0]        name_ref;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_id;
      logic signed [31:0] out_score;
      logic [15:0]        out_name_ref;
      logic [1:0]         status;
      logic [7:0]         fill_count;
   } rsp_type;

   // one stored record, one memory word
   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] score;
      logic [15:0]        name_ref;
   } record_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_SORT_RDI,
      ST_SORT_LDI,
      ST_SORT_CMP,
      ST_SORT_PUT,
      ST_SORT_END
   } state_type;

endpackage
`default_nettype wire

>>> src/srs_mem.sv
// srs_mem: record memory, one write port and one registered read port.
// Depends on srs_pkg for record_type.
`default_nettype none
module srs_mem #(
   parameter int DEPTH = srs_pkg::DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire srs_pkg::record_type        wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output srs_pkg::record_type             rd_data
);
   import srs_pkg::*;

   record_type mem [DEPTH];
   record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> src/sortable_record_stack.sv
// sortable_record_stack: LIFO record store with in-place stable key sort.
// Depends on srs_pkg and srs_mem.
`default_nettype none
//
//   channel  ports                         direction  carries
//   request  req_valid / req_stall / req   in         mode + record (req_type)
//   response rsp_valid / rsp_stall / rsp   out        popped record + status
//
// Push, refused push, unused mode, empty pop/sort, sort of one record: answered
// straight from idle. Pop: read issued on accept, response from the read data.
// Sort of n > 1 records: insertion sort through the single memory read port;
// each pass loads the record (RDI, LDI), shifts each larger record up (CMP)
// and writes it into the hole (CMP, or PUT at the bottom); response from END.
// Reset clears the fill count, FSM and response valid; memory is not cleared.
// A stalled response holds off new requests, as do the busy pop/sort cycles.
module sortable_record_stack #(
   parameter int DEPTH = srs_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire srs_pkg::req_type req,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output srs_pkg::rsp_type      rsp
);
   import srs_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;   // records held
   logic [CW-1:0] i_ff, i_in;           // sort: record being inserted
   logic [AW-1:0] j_ff, j_in;           // sort: hole position
   record_type cur_ff, cur_in;          // sort: record being inserted
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic          mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   record_type    mem_wr_data, mem_rd_data;

   logic out_free, req_accept, is_full, is_empty, key_gt, last_pass;
   record_type req_rec;

   srs_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign is_full    = (count_ff == CW'(DEPTH));
   assign is_empty   = (count_ff == '0);
   // strict compare keeps equal keys in order
   assign key_gt     = mem_rd_data.key > cur_ff.key;
   assign last_pass  = (CW'(i_ff + CW'(1)) == count_ff);

   assign req_rec.key      = req.student_id;
   assign req_rec.score    = req.score;
   assign req_rec.name_ref = req.name_ref;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req.mode == MODE_POP && !is_empty) begin
                  state_in = ST_POP;
               end else if (req.mode == MODE_SORT && count_ff > CW'(1)) begin
                  state_in = ST_SORT_RDI;
               end
            end
         end
         ST_POP: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_SORT_RDI: state_in = ST_SORT_LDI;
         ST_SORT_LDI: state_in = ST_SORT_CMP;
         ST_SORT_CMP: begin
            if (key_gt) begin
               if (j_ff == AW'(1)) state_in = ST_SORT_PUT;
            end else begin
               state_in = last_pass ? ST_SORT_END : ST_SORT_RDI;
            end
         end
         ST_SORT_PUT: state_in = last_pass ? ST_SORT_END : ST_SORT_RDI;
         ST_SORT_END: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      mem_wr_en    = 1'b0;
      mem_wr_addr  = count_ff[AW-1:0];
      mem_wr_data  = req_rec;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.status     = STATUS_DONE;
               rsp_in.fill_count = 8'(count_ff);
               priority if (req.mode == MODE_PUSH) begin
                  if (is_full) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     mem_wr_en = 1'b1;
                     count_in  = CW'(count_ff + CW'(1));
                     rsp_in.fill_count = 8'(count_in);
                  end
               end else if (req.mode == MODE_POP) begin
                  if (is_empty) begin
                     rsp_in.status = STATUS_EMPTY;
                  end else begin
                     // response follows once read data is back
                     rsp_valid_in = 1'b0;
                     mem_rd_en    = 1'b1;
                     count_in     = CW'(count_ff - CW'(1));
                     mem_rd_addr  = count_in[AW-1:0];
                  end
               end else if (req.mode == MODE_SORT) begin
                  if (is_empty) begin
                     rsp_in.status = STATUS_EMPTY;
                  end else if (count_ff > CW'(1)) begin
                     rsp_valid_in = 1'b0;
                     i_in         = CW'(1);
                  end
               end else begin
                  // unused mode: no change
               end
            end
         end
         ST_POP: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.out_id       = mem_rd_data.key;
               rsp_in.out_score    = mem_rd_data.score;
               rsp_in.out_name_ref = mem_rd_data.name_ref;
               rsp_in.status       = STATUS_DONE;
               rsp_in.fill_count   = 8'(count_ff);
            end
         end
         ST_SORT_RDI: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = i_ff[AW-1:0];
         end
         ST_SORT_LDI: begin
            cur_in      = mem_rd_data;
            j_in        = i_ff[AW-1:0];
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(i_ff[AW-1:0] - AW'(1));
         end
         ST_SORT_CMP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = j_ff;
            if (key_gt) begin
               // shift the larger record up, look one lower
               mem_wr_data = mem_rd_data;
               j_in        = AW'(j_ff - AW'(1));
               mem_rd_en   = (j_ff != AW'(1));
               mem_rd_addr = AW'(j_ff - AW'(2));
            end else begin
               mem_wr_data = cur_ff;
               i_in        = CW'(i_ff + CW'(1));
            end
         end
         ST_SORT_PUT: begin
            // hole reached the bottom
            mem_wr_en   = 1'b1;
            mem_wr_addr = j_ff;
            mem_wr_data = cur_ff;
            i_in        = CW'(i_ff + CW'(1));
         end
         ST_SORT_END: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in            = '0;
               rsp_in.status     = STATUS_DONE;
               rsp_in.fill_count = 8'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire
